[src/slr_pkg.sv]
// Package for the serpentine line rasterizer: widths, register codes, payload types.
package slr_pkg;

  localparam int CoordW     = 5;
  localparam int SideW      = 6;
  localparam int ColorW     = 24;
  localparam int IndexW     = 10;
  localparam int ErrW       = 7;
  localparam int CfgIndexW  = 2;
  localparam int WallLimit  = 32;
  localparam int MaxSideDef = 32;
  localparam int QueueDepth = 2;

  typedef enum logic [CfgIndexW-1:0] {
    CfgRowWidth  = 2'd0,
    CfgRowCount  = 2'd1,
    CfgDrawColor = 2'd2
  } slr_cfg_idx_e;

  typedef struct packed {
    logic [CoordW-1:0] start_x;
    logic [CoordW-1:0] start_y;
    logic [CoordW-1:0] end_x;
    logic [CoordW-1:0] end_y;
  } slr_cmd_t;

  typedef struct packed {
    logic [IndexW-1:0] pixel_index;
    logic              visible;
    logic [ColorW-1:0] pixel_color;
    logic              last_point;
  } slr_result_t;

  typedef struct packed {
    logic [SideW-1:0]  row_width;
    logic [SideW-1:0]  row_count;
    logic [ColorW-1:0] draw_color;
  } slr_cfg_t;

  // Classified line, as handed from the front to the walker.
  typedef struct packed {
    logic [CoordW-1:0]    x;
    logic [CoordW-1:0]    y;
    logic [CoordW-1:0]    xe;
    logic [CoordW-1:0]    ye;
    logic [CoordW-1:0]    dx;
    logic [CoordW-1:0]    dy;
    logic                 sx_neg;
    logic                 sy_neg;
    logic signed [ErrW-1:0] err;
  } slr_line_t;

endpackage

[src/serpentine_line_rasterizer.sv]
// Top level of the serpentine line rasterizer: config registers, front end, queue, walker.
// A line's first point passes the queue, the walker's line register and its result register,
// and lines wait in the queue while the walker is busy. The walker emits one point per cycle
// while it holds a line; queued lines follow back to back, each of at most MaxSide points.
// busy is high only while the two-entry line queue is full; results cannot be stalled.
// Reset clears control state and sets row_width and row_count to 16, draw_color to 0.
module serpentine_line_rasterizer
  import slr_pkg::*;
#(
  parameter int MaxSide = MaxSideDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  output logic                 busy,
  input  slr_cmd_t             cmd_i,
  output logic                 result_strobe_o,
  output slr_result_t          result_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CfgIndexW-1:0] cfg_index_i,
  input  logic [ColorW-1:0]    cfg_data_i
);

  slr_cfg_t  cfg_q, cfg_d;
  slr_line_t front_line, queue_line;
  logic      queue_full, queue_valid, queue_pop, push;

  function automatic logic [SideW-1:0] clamp_side(input logic [SideW-1:0] v);
    if (v == '0) begin
      return SideW'(1);
    end
    if (v > SideW'(WallLimit)) begin
      return SideW'(WallLimit);
    end
    return v;
  endfunction

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        CfgRowWidth:  cfg_d.row_width  = clamp_side(cfg_data_i[SideW-1:0]);
        CfgRowCount:  cfg_d.row_count  = clamp_side(cfg_data_i[SideW-1:0]);
        CfgDrawColor: cfg_d.draw_color = cfg_data_i;
        default:      cfg_d            = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.row_width  <= SideW'(16);
      cfg_q.row_count  <= SideW'(16);
      cfg_q.draw_color <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign busy = queue_full;
  assign push = start && !queue_full;

  slr_front #(
    .MaxSide(MaxSide)
  ) u_front (
    .cmd_i (cmd_i),
    .line_o(front_line)
  );

  slr_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_data_i(front_line),
    .full_o     (queue_full),
    .pop_i      (queue_pop),
    .valid_o    (queue_valid),
    .pop_data_o (queue_line)
  );

  slr_walker #(
    .MaxSide(MaxSide)
  ) u_walker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg_q),
    .line_valid_i   (queue_valid),
    .line_i         (queue_line),
    .line_pop_o     (queue_pop),
    .result_strobe_o(result_strobe_o),
    .result_o       (result_o)
  );

endmodule

[src/slr_front.sv]
// Command front end: coordinate limiting and line setup (deltas, directions, initial error).
module slr_front
  import slr_pkg::*;
#(
  parameter int MaxSide = MaxSideDef
) (
  input  slr_cmd_t  cmd_i,
  output slr_line_t line_o
);

  localparam logic [SideW:0] CoordMax = (SideW+1)'(MaxSide - 1);

  function automatic logic [CoordW-1:0] limit_coord(input logic [CoordW-1:0] c);
    logic [SideW:0] wide;
    wide = {{(SideW+1-CoordW){1'b0}}, c};
    if (wide > CoordMax) begin
      return CoordMax[CoordW-1:0];
    end
    return c;
  endfunction

  logic [CoordW-1:0] x, y, xe, ye, dx, dy;

  always_comb begin
    x  = limit_coord(cmd_i.start_x);
    y  = limit_coord(cmd_i.start_y);
    xe = limit_coord(cmd_i.end_x);
    ye = limit_coord(cmd_i.end_y);
    dx = (xe > x) ? xe - x : x - xe;
    dy = (ye > y) ? ye - y : y - ye;

    line_o.x      = x;
    line_o.y      = y;
    line_o.xe     = xe;
    line_o.ye     = ye;
    line_o.dx     = dx;
    line_o.dy     = dy;
    line_o.sx_neg = !(x < xe);
    line_o.sy_neg = !(y < ye);
    if (dx > dy) begin
      line_o.err = $signed({{(ErrW-CoordW){1'b0}}, dx >> 1});
    end else begin
      line_o.err = -$signed({{(ErrW-CoordW){1'b0}}, dy >> 1});
    end
  end

endmodule

[src/slr_queue.sv]
// Short queue of classified lines between the front end and the walker.
module slr_queue
  import slr_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  slr_line_t push_data_i,
  output logic      full_o,
  input  logic      pop_i,
  output logic      valid_o,
  output slr_line_t pop_data_o
);

  localparam int PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int CntW = $clog2(QueueDepth + 1);

  slr_line_t           mem_q [QueueDepth];
  logic [PtrW-1:0]     wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]     rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]     cnt_q, cnt_d;

  function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
    if (p == PtrW'(QueueDepth - 1)) begin
      return '0;
    end
    return p + 1'b1;
  endfunction

  assign full_o     = (cnt_q == CntW'(QueueDepth));
  assign valid_o    = (cnt_q != '0);
  assign pop_data_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? ptr_inc(wr_ptr_q) : wr_ptr_q;
    rd_ptr_d = pop_i  ? ptr_inc(rd_ptr_q) : rd_ptr_q;
    cnt_d    = cnt_q + CntW'(push_i) - CntW'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

[src/slr_walker.sv]
// Line walker: Bresenham stepping, serpentine index mapping and registered result.
module slr_walker
  import slr_pkg::*;
#(
  parameter int MaxSide = MaxSideDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  slr_cfg_t    cfg_i,
  input  logic        line_valid_i,
  input  slr_line_t   line_i,
  output logic        line_pop_o,
  output logic        result_strobe_o,
  output slr_result_t result_o
);

  localparam int CntW = (MaxSide > 1) ? $clog2(MaxSide) : 1;

  logic                   active_q, active_d;
  slr_line_t              line_q, line_d;
  logic [CntW-1:0]        cnt_q, cnt_d;
  logic                   strobe_q;
  slr_result_t            result_q, result_d;

  logic                   last;
  logic                   done;
  logic                   step_x, step_y;
  logic signed [ErrW-1:0] dx_s, dy_s, err_n;
  logic                   vis;
  logic [IndexW-1:0]      prod;
  logic [SideW-1:0]       col;
  logic [SideW-1:0]       x_w;

  always_comb begin
    last   = (line_q.x == line_q.xe) && (line_q.y == line_q.ye);
    done   = last || (cnt_q == CntW'(MaxSide - 1));
    dx_s   = $signed({{(ErrW-CoordW){1'b0}}, line_q.dx});
    dy_s   = $signed({{(ErrW-CoordW){1'b0}}, line_q.dy});
    step_x = line_q.err > -dx_s;
    step_y = line_q.err < dy_s;
    err_n  = line_q.err - (step_x ? dy_s : '0) + (step_y ? dx_s : '0);

    x_w  = {{(SideW-CoordW){1'b0}}, line_q.x};
    vis  = (x_w < cfg_i.row_width) &&
           ({{(SideW-CoordW){1'b0}}, line_q.y} < cfg_i.row_count);
    prod = IndexW'(cfg_i.row_width * line_q.y);
    col  = line_q.y[0] ? x_w : (cfg_i.row_width - 1'b1 - x_w);

    result_d.pixel_index = vis ? (prod + IndexW'(col)) : '0;
    result_d.visible     = vis;
    result_d.pixel_color = cfg_i.draw_color;
    result_d.last_point  = last;

    line_pop_o = line_valid_i && (!active_q || done);

    line_d        = line_q;
    line_d.err    = err_n;
    if (step_x) begin
      line_d.x = line_q.sx_neg ? line_q.x - 1'b1 : line_q.x + 1'b1;
    end
    if (step_y) begin
      line_d.y = line_q.sy_neg ? line_q.y - 1'b1 : line_q.y + 1'b1;
    end
    cnt_d    = cnt_q + 1'b1;
    active_d = active_q && !done;
    if (line_pop_o) begin
      line_d   = line_i;
      cnt_d    = '0;
      active_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      strobe_q <= 1'b0;
      cnt_q    <= '0;
    end else begin
      active_q <= active_d;
      strobe_q <= active_q;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    line_q   <= line_d;
    result_q <= result_d;
  end

  assign result_strobe_o = strobe_q;
  assign result_o        = result_q;

endmodule

[src/slr_checker.sv]
// Port-level checker for the serpentine line rasterizer, bound to the top level.
module slr_checker
  import slr_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        start,
  input logic        busy,
  input logic        result_strobe_o,
  input slr_result_t result_o
);

  a_reset_quiet: assert property (@(posedge clk_i)
    !rst_ni |=> (!result_strobe_o && !busy))
    else $error("outputs active during reset");

  a_line_contiguous: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_strobe_o && !result_o.last_point) |=> result_strobe_o)
    else $error("gap inside a line");

  a_hidden_index_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_strobe_o && !result_o.visible) |-> (result_o.pixel_index == '0))
    else $error("off-wall point with nonzero index");

  a_busy_needs_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(busy) |-> $past(start))
    else $error("busy rose without a command transfer");

endmodule

bind serpentine_line_rasterizer slr_checker u_slr_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start          (start),
  .busy           (busy),
  .result_strobe_o(result_strobe_o),
  .result_o       (result_o)
);
